// ===== rtl/nsst_pkg.sv =====
// ----------------------------------------------------------------------------
// nsst_pkg: shared types and codes for the node signal strength table
//
// Holds the request and result item types, result codes, the controller
// state encoding and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package nsst_pkg;

   // Entry count width, fixed by the result item format
   localparam int CNT_W         = 6;
   localparam int ID_W          = 8;
   localparam int RSSI_W        = 8;
   localparam int DEPTH_DEFAULT = 32;

   // Result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ENTRY  = 2'd2;

   // Report status codes
   localparam logic [1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_IGNORED  = 2'd3;

   // Request types
   localparam logic REQ_REPORT = 1'b0;
   localparam logic REQ_DUMP   = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [ID_W-1:0]          report_id;
      logic signed [RSSI_W-1:0] report_rssi;
   } req_item_type;

   typedef struct packed {
      logic [1:0]               result_kind;
      logic [1:0]               report_status;
      logic [CNT_W-1:0]         entry_count;
      logic [ID_W-1:0]          entry_id;
      logic signed [RSSI_W-1:0] entry_rssi;
      logic                     last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_UPDATE,
      ST_INSERT,
      ST_FULL,
      ST_IGNORE,
      ST_HEADER,
      ST_DUMP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       issue;
      logic       write_update;
      logic       write_append;
      logic       emit;
      logic [1:0] emit_kind;
      logic [1:0] emit_status;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_dump;
      logic id_zero;
      logic used_zero;
      logic table_full;
      logic addr_at_end;
      logic cmp_valid;
      logic hit;
      logic cmp_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/node_signal_strength_table.sv =====
// ----------------------------------------------------------------------------
// node_signal_strength_table: per-node last signal strength table
//
// Table of node identifiers in first-seen order, each with its last strength.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: a strength report (identifier and signed
//   strength) or a dump. A request is taken when req_valid is high and
//   req_stall low; req_stall is high while a request is in work.
//   rsp_* returns the results: one status per report; for a dump a header
//   with the entry count, then each entry in insertion order. last marks the
//   final result of a request.
//   Report: the request is latched and dispatched, the first memory read is
//   started, then the entries are searched one per cycle through the single
//   read port, and the status is emitted. Dump: latch, dispatch and header,
//   then one entry per cycle while rsp_stall is low.
//   Reset clears the entry count; no clearing pass is run, the store holds
//   nothing that is read before it is written.
//   A stall on rsp_stall holds the result register and pauses the sequencer;
//   the next request is taken once the last result sits in that register.
// ----------------------------------------------------------------------------
module node_signal_strength_table #(
   parameter int TABLE_DEPTH = nsst_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nsst_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nsst_pkg::rsp_item_type rsp_item
);

   nsst_pkg::ctrl_cmd_type  cmd;
   nsst_pkg::dp_status_type sts;

   // Sequencer
   nsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store and result path
   nsst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/nsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// nsst_ctrl: sequencer for the node signal strength table
//
// Steps one request at a time through lookup and update or append, a full or
// ignored status, or a dump's header and entry sweep, commanding the datapath.
// ----------------------------------------------------------------------------
module nsst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nsst_pkg::dp_status_type sts,
   output nsst_pkg::ctrl_cmd_type  cmd
);

   nsst_pkg::state_type state_ff;
   nsst_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nsst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nsst_pkg::ST_IDLE: begin
            if (req_valid) state_in = nsst_pkg::ST_DISPATCH;
         end
         nsst_pkg::ST_DISPATCH: begin
            if (sts.is_dump)        state_in = nsst_pkg::ST_HEADER;
            else if (sts.id_zero)   state_in = nsst_pkg::ST_IGNORE;
            else if (sts.used_zero) state_in = nsst_pkg::ST_INSERT;
            else                    state_in = nsst_pkg::ST_SCAN;
         end
         nsst_pkg::ST_SCAN: begin
            if (sts.cmp_valid && sts.hit) begin
               state_in = nsst_pkg::ST_UPDATE;
            end else if (sts.cmp_valid && sts.cmp_last) begin
               state_in = sts.table_full ? nsst_pkg::ST_FULL : nsst_pkg::ST_INSERT;
            end
         end
         nsst_pkg::ST_UPDATE,
         nsst_pkg::ST_INSERT,
         nsst_pkg::ST_FULL,
         nsst_pkg::ST_IGNORE: begin
            if (sts.out_free) state_in = nsst_pkg::ST_IDLE;
         end
         nsst_pkg::ST_HEADER: begin
            if (sts.out_free) begin
               state_in = sts.used_zero ? nsst_pkg::ST_IDLE : nsst_pkg::ST_DUMP;
            end
         end
         nsst_pkg::ST_DUMP: begin
            if (sts.out_free && sts.cmp_last) state_in = nsst_pkg::ST_IDLE;
         end
         default: state_in = nsst_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         nsst_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         nsst_pkg::ST_DISPATCH: begin
         end
         nsst_pkg::ST_SCAN: begin
            cmd.issue = !(sts.cmp_valid && sts.hit) && !sts.addr_at_end;
         end
         nsst_pkg::ST_UPDATE: begin
            cmd.emit         = sts.out_free;
            cmd.write_update = sts.out_free;
            cmd.emit_kind    = nsst_pkg::KIND_STATUS;
            cmd.emit_status  = nsst_pkg::STATUS_UPDATED;
         end
         nsst_pkg::ST_INSERT: begin
            cmd.emit         = sts.out_free;
            cmd.write_append = sts.out_free;
            cmd.emit_kind    = nsst_pkg::KIND_STATUS;
            cmd.emit_status  = nsst_pkg::STATUS_INSERTED;
         end
         nsst_pkg::ST_FULL: begin
            cmd.emit        = sts.out_free;
            cmd.emit_kind   = nsst_pkg::KIND_STATUS;
            cmd.emit_status = nsst_pkg::STATUS_FULL;
         end
         nsst_pkg::ST_IGNORE: begin
            cmd.emit        = sts.out_free;
            cmd.emit_kind   = nsst_pkg::KIND_STATUS;
            cmd.emit_status = nsst_pkg::STATUS_IGNORED;
         end
         nsst_pkg::ST_HEADER: begin
            cmd.emit      = sts.out_free;
            cmd.emit_kind = nsst_pkg::KIND_HEADER;
            cmd.issue     = sts.out_free && !sts.used_zero;
         end
         nsst_pkg::ST_DUMP: begin
            cmd.emit      = sts.out_free;
            cmd.emit_kind = nsst_pkg::KIND_ENTRY;
            cmd.issue     = sts.out_free && !sts.cmp_last;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/nsst_datapath.sv =====
// ----------------------------------------------------------------------------
// nsst_datapath: entry store, counters and result register
//
// Holds the identifier/strength memory, the entry count, the read pointer
// with its compare stage, the latched request and the result register.
// ----------------------------------------------------------------------------
module nsst_datapath #(
   parameter int TABLE_DEPTH = nsst_pkg::DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nsst_pkg::req_item_type  req_item,
   input  nsst_pkg::ctrl_cmd_type  cmd,
   output nsst_pkg::dp_status_type sts,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output nsst_pkg::rsp_item_type  rsp_item
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = nsst_pkg::CNT_W;
   localparam int WORD_W = nsst_pkg::ID_W + nsst_pkg::RSSI_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Entry store: identifier in the upper byte, strength in the lower
   logic [WORD_W-1:0] mem [TABLE_DEPTH];

   nsst_pkg::req_item_type req_ff;
   logic [CNT_W-1:0]       used_ff;
   logic [CNT_W-1:0]       used_in;
   logic [CNT_W-1:0]       addr_ff;
   logic [CNT_W-1:0]       addr_in;
   logic [CNT_W-1:0]       cmp_idx_ff;
   logic                   cmp_valid_ff;
   logic [WORD_W-1:0]      rd_data_ff;
   nsst_pkg::rsp_item_type rsp_ff;
   nsst_pkg::rsp_item_type rsp_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [WORD_W-1:0] wr_data;
   logic              out_free;
   logic              cmp_last;
   logic              table_full;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cmp_last   = (cmp_idx_ff + CNT_W'(1)) == used_ff;
   assign table_full = (used_ff == DEPTH_CNT);

   // Status toward the controller
   always_comb begin
      sts.is_dump     = (req_ff.req_type == nsst_pkg::REQ_DUMP);
      sts.id_zero     = (req_ff.report_id == '0);
      sts.used_zero   = (used_ff == '0);
      sts.table_full  = table_full;
      sts.addr_at_end = (addr_ff == used_ff);
      sts.cmp_valid   = cmp_valid_ff;
      sts.hit         = (rd_data_ff[WORD_W-1 -: nsst_pkg::ID_W] == req_ff.report_id);
      sts.cmp_last    = cmp_last;
      sts.out_free    = out_free;
   end

   // Latch the accepted request
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_item;
   end

   // Entry count and read pointer
   always_comb begin
      used_in = used_ff;
      if (cmd.write_append) used_in = used_ff + CNT_W'(1);
      addr_in = addr_ff;
      if (cmd.load_req)   addr_in = '0;
      else if (cmd.issue) addr_in = addr_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         addr_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         addr_ff      <= addr_in;
         cmp_valid_ff <= cmd.issue;
      end
   end

   // Remember which entry the read data belongs to
   always_ff @(posedge clock) begin
      if (cmd.issue) cmp_idx_ff <= addr_ff;
   end

   // Write port: refresh a matched entry or append at the end
   always_comb begin
      wr_en   = cmd.write_update || cmd.write_append;
      wr_idx  = cmd.write_update ? cmp_idx_ff[IDX_W-1:0] : used_ff[IDX_W-1:0];
      wr_data = {req_ff.report_id, req_ff.report_rssi};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (cmd.issue) rd_data_ff <= mem[addr_ff[IDX_W-1:0]];
   end

   // Build the next result
   always_comb begin
      rsp_in             = '0;
      rsp_in.result_kind = cmd.emit_kind;
      case (cmd.emit_kind)
         nsst_pkg::KIND_HEADER: begin
            rsp_in.entry_count = used_ff;
            rsp_in.last        = (used_ff == '0);
         end
         nsst_pkg::KIND_ENTRY: begin
            rsp_in.entry_id   = rd_data_ff[WORD_W-1 -: nsst_pkg::ID_W];
            rsp_in.entry_rssi = rd_data_ff[nsst_pkg::RSSI_W-1:0];
            rsp_in.last       = cmp_last;
         end
         default: begin
            rsp_in.report_status = cmd.emit_status;
            rsp_in.last          = 1'b1;
         end
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)           rsp_valid_in = 1'b1;
      else if (!rsp_stall)    rsp_valid_in = 1'b0;
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= DEPTH_CNT)
      else $error("entry count beyond table depth");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.write_append |-> !table_full)
      else $error("append into a full table");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result overwritten before it was taken");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (addr_ff < used_ff))
      else $error("read beyond the stored entries");

endmodule
